// ===== hw/rtl/uart_rtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rtm_pkg
// Shared types and register codes for the serial port register block.
// ----------------------------------------------------------------------------
package uart_rtm_pkg;

	localparam int unsigned CycleW   = 64;
	localparam int unsigned BaudW    = 16;
	localparam int unsigned OversamW = 4;  // divisor is (baud + 1) * 16
	localparam int unsigned BitDivW  = BaudW + OversamW + 1;
	localparam int unsigned StepW    = $clog2(CycleW);

	localparam logic [3:0] FrameLen8 = 4'd10;
	localparam logic [3:0] FrameLen9 = 4'd11;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [2:0] SEL_BAUD_LO = 3'd0;
	localparam logic [2:0] SEL_BAUD_HI = 3'd1;
	localparam logic [2:0] SEL_CTRL    = 3'd2;
	localparam logic [2:0] SEL_STAT    = 3'd3;
	localparam logic [2:0] SEL_DATA    = 3'd4;

	// control bit positions
	localparam int unsigned C_RXCIE = 7;
	localparam int unsigned C_TXCIE = 6;
	localparam int unsigned C_UDRIE = 5;
	localparam int unsigned C_RXEN  = 4;
	localparam int unsigned C_TXEN  = 3;
	localparam int unsigned C_CHR9  = 2;
	localparam int unsigned C_RXB8  = 1;

	// status bit positions
	localparam int unsigned S_RXC  = 7;
	localparam int unsigned S_TXC  = 6;
	localparam int unsigned S_UDRE = 5;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [2:0]        reg_sel;
		logic [7:0]        write_data;
		logic [8:0]        rx_data;
		logic [CycleW-1:0] cycle_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_rx;
		logic       irq_tx;
		logic       irq_udre;
	} out_item_t;

endpackage

// ===== hw/rtl/uart_register_and_tx_timing_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_and_tx_timing_model
// Serial port register block with transmit frame timing and interrupt pulses.
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  --------+---------------------------------+------------------------------
//  in      | in_valid, in_ready, in_item     | one command: tick, read, write, none
//  out     | out_valid, out_ready, out_item  | one result per command
//
//  read, write and none: accepted in idle and answered in the following cycle.
//  tick with timing active: idle, then the divide state, then finish; a restoring
//  divider takes one bit of the 64-bit cycle number per cycle to get its remainder.
//  tick with timing idle: goes from idle straight to the finish state.
//  a finished result sits in the output register; a stalled output holds the
//  next result back in the finish state. reset clears all registers except
//  the held baud high byte and the cycle number shift register.
// ----------------------------------------------------------------------------
module uart_register_and_tx_timing_model
	import uart_rtm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [BaudW-1:0]   baud_div_q;
	logic [7:0]         baud_hi_q;
	logic [7:0]         ctrl_q;
	logic [7:0]         stat_q;
	logic               udre_sh_q;
	logic               poll_q;
	logic               tx_act_q;
	logic [7:0]         rx_hold_q;
	logic [3:0]         frame_q;
	logic [BitDivW-1:0] bdiv_q;
	logic [CycleW-1:0]  ck_q;
	logic [BitDivW-1:0] rem_q;
	logic [StepW-1:0]   step_q;
	logic               hit_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               out_free;
	logic               out_load;
	logic               accept;
	logic [BitDivW:0]   rem_sh;
	logic [BitDivW:0]   rem_sub;
	logic [3:0]         frame_len;

	// tick finish values
	logic [3:0] t_frame;
	logic [7:0] t_stat;
	logic       t_tx_act;
	logic       t_udre_sh;
	logic       t_irq_rx;
	logic       t_irq_tx;
	logic       t_irq_udre;

	// read values
	logic [7:0] rd_data;
	logic [7:0] rd_hold;
	logic [7:0] rd_ctrl;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign frame_len = ctrl_q[C_CHR9] ? FrameLen9 : FrameLen8;

	// a new result is loaded this cycle
	assign out_load = (accept && (in_item.cmd != CMD_TICK))
		|| ((state_q == ST_FIN) && out_free);

	// one restoring step of the remainder
	assign rem_sh  = {rem_q, ck_q[CycleW-1]};
	assign rem_sub = rem_sh - {1'b0, bdiv_q};

	always_comb begin
		t_frame    = frame_q;
		t_stat     = stat_q;
		t_tx_act   = tx_act_q;
		t_udre_sh  = udre_sh_q;
		t_irq_rx   = 1'b0;
		t_irq_tx   = 1'b0;
		t_irq_udre = 1'b0;
		if (hit_q) begin
			t_frame = frame_q - 4'd1;
			if (t_frame == 4'd0) begin
				if (stat_q[S_UDRE]) begin
					t_stat[S_TXC] = 1'b1;
					t_tx_act      = 1'b0;
				end else begin
					t_stat[S_UDRE] = 1'b1;
					t_udre_sh      = 1'b1;
					t_frame        = frame_len;
				end
			end
		end
		if (poll_q) begin
			t_irq_rx = ctrl_q[C_RXCIE] && t_stat[S_RXC];
			if (ctrl_q[C_TXCIE] && t_stat[S_TXC]) begin
				t_irq_tx      = 1'b1;
				t_stat[S_TXC] = 1'b0;
			end
			if (ctrl_q[C_UDRIE] && t_stat[S_UDRE] && t_udre_sh) begin
				t_irq_udre = 1'b1;
				t_udre_sh  = 1'b0;
			end
		end
	end

	always_comb begin
		rd_hold = rx_hold_q;
		rd_ctrl = ctrl_q;
		if (tx_act_q) begin
			rd_hold         = in_item.rx_data[7:0];
			rd_ctrl[C_RXB8] = ctrl_q[C_CHR9] && in_item.rx_data[8];
		end
		case (in_item.reg_sel)
			SEL_BAUD_LO: rd_data = baud_div_q[7:0];
			SEL_BAUD_HI: rd_data = baud_div_q[15:8];
			SEL_CTRL:    rd_data = ctrl_q;
			SEL_STAT:    rd_data = stat_q;
			SEL_DATA:    rd_data = rd_hold;
			default:     rd_data = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			baud_div_q  <= '0;
			ctrl_q      <= '0;
			stat_q      <= '0;
			udre_sh_q   <= 1'b0;
			poll_q      <= 1'b0;
			tx_act_q    <= 1'b0;
			rx_hold_q   <= '0;
			frame_q     <= '0;
			bdiv_q      <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_t'(in_item.cmd))
							CMD_TICK: begin
								rem_q  <= '0;
								step_q <= '0;
								hit_q  <= 1'b0;
								if (tx_act_q && (bdiv_q != '0)) begin
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_FIN;
								end
							end
							CMD_READ: begin
								out_q       <= '{read_data: rd_data, default: 1'b0};
								if (in_item.reg_sel == SEL_DATA) begin
									stat_q[S_RXC] <= 1'b0;
									rx_hold_q     <= rd_hold;
									ctrl_q        <= rd_ctrl;
								end
							end
							CMD_WRITE: begin
								out_q       <= '0;
								case (in_item.reg_sel)
									SEL_BAUD_LO: begin
										baud_div_q <= {baud_hi_q, in_item.write_data};
									end
									SEL_CTRL: begin
										ctrl_q <= in_item.write_data;
										poll_q <= (in_item.write_data[C_TXEN]
											&& in_item.write_data[C_TXCIE])
											|| (in_item.write_data[C_RXEN]
											&& in_item.write_data[C_RXCIE])
											|| in_item.write_data[C_UDRIE];
									end
									SEL_STAT: begin
										if (in_item.write_data[S_TXC]) begin
											stat_q[S_TXC] <= 1'b0;
										end
									end
									SEL_DATA: begin
										stat_q[S_UDRE] <= !stat_q[S_UDRE];
										udre_sh_q      <= !stat_q[S_UDRE];
										bdiv_q   <= {1'b0, baud_div_q, {OversamW{1'b0}}}
											+ BitDivW'(1 << OversamW);
										tx_act_q <= 1'b1;
										frame_q  <= frame_len;
									end
									default: begin
									end
								endcase
							end
							default: begin
								out_q       <= '0;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (rem_sub[BitDivW]) begin
						rem_q <= rem_sh[BitDivW-1:0];
					end else begin
						rem_q <= rem_sub[BitDivW-1:0];
					end
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(CycleW - 1)) begin
						state_q <= ST_FIN;
						hit_q   <= rem_sub[BitDivW] ? (rem_sh == '0) : (rem_sub == '0);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						frame_q     <= t_frame;
						stat_q      <= t_stat;
						tx_act_q    <= t_tx_act;
						udre_sh_q   <= t_udre_sh;
						out_q       <= '{read_data: 8'd0, irq_rx: t_irq_rx,
							irq_tx: t_irq_tx, irq_udre: t_irq_udre};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cycle number shifts out msb first while dividing
	always_ff @(posedge clk) begin
		if (accept) begin
			ck_q <= in_item.cycle_count;
		end else if (state_q == ST_DIV) begin
			ck_q <= {ck_q[CycleW-2:0], 1'b0};
		end
	end

	// baud high byte has no reset value
	always_ff @(posedge clk) begin
		if (accept && (in_item.cmd == CMD_WRITE) && (in_item.reg_sel == SEL_BAUD_HI)) begin
			baud_hi_q <= in_item.write_data;
		end
	end

`ifndef SYNTH
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < bdiv_q))
		else $error("remainder not below divisor");

	a_shadow_implies_udre: assert property (@(posedge clk) disable iff (!arst_n)
		udre_sh_q |-> stat_q[S_UDRE])
		else $error("udre shadow set without udre");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_act_q |-> (frame_q <= FrameLen9))
		else $error("frame counter out of range");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("ready while a tick is in progress");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick, read and write commands into the serial port register block
// and checks each reply against a cycle-free model of the registers, the
// transmit frame counter and the interrupt pulses. Both channels stall at
// random, and the reply side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
	import uart_rtm_pkg::*;

	localparam int unsigned RandomCmds = 450;
	localparam int unsigned IdleLimit  = 5000;
	localparam int unsigned LongHold   = 600;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	uart_register_and_tx_timing_model uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	in_item_t  cmd_backlog[$];
	out_item_t awaited_replies[$];

	// register model state
	logic [BaudW-1:0]   baud_q        = '0;
	logic [7:0]         hi_hold_q     = '0;
	logic [7:0]         ctrl_q        = '0;
	logic [7:0]         stat_q        = '0;
	logic               udre_pend_q   = 1'b0;
	logic               poll_on_q     = 1'b0;
	logic               tx_on_q       = 1'b0;
	logic [7:0]         rx_byte_q     = '0;
	logic [3:0]         frames_left_q = '0;
	logic [BitDivW-1:0] bit_div_q     = '0;

	function automatic logic [3:0] frame_length();
		return ctrl_q[C_CHR9] ? FrameLen9 : FrameLen8;
	endfunction

	function automatic out_item_t apply_uart_command(in_item_t it);
		out_item_t r;
		logic [7:0] v;
		r = '0;
		v = it.write_data;
		case (cmd_t'(it.cmd))
			CMD_TICK: begin
				if (tx_on_q && bit_div_q != '0 &&
				    (it.cycle_count % 64'(bit_div_q)) == 64'd0) begin
					frames_left_q = frames_left_q - 4'd1;
					if (frames_left_q == 4'd0) begin
						if (stat_q[S_UDRE]) begin
							stat_q[S_TXC] = 1'b1;
							tx_on_q = 1'b0;
						end else begin
							stat_q[S_UDRE] = 1'b1;
							udre_pend_q = 1'b1;
							frames_left_q = frame_length();
						end
					end
				end
				if (poll_on_q) begin
					if (ctrl_q[C_RXCIE] && stat_q[S_RXC])
						r.irq_rx = 1'b1;
					if (ctrl_q[C_TXCIE] && stat_q[S_TXC]) begin
						r.irq_tx = 1'b1;
						stat_q[S_TXC] = 1'b0;
					end
					if (ctrl_q[C_UDRIE] && stat_q[S_UDRE] && udre_pend_q) begin
						r.irq_udre = 1'b1;
						udre_pend_q = 1'b0;
					end
				end
			end
			CMD_READ: begin
				case (it.reg_sel)
					SEL_BAUD_LO: r.read_data = baud_q[7:0];
					SEL_BAUD_HI: r.read_data = baud_q[15:8];
					SEL_CTRL:    r.read_data = ctrl_q;
					SEL_STAT:    r.read_data = stat_q;
					SEL_DATA: begin
						stat_q[S_RXC] = 1'b0;
						if (tx_on_q) begin
							rx_byte_q = it.rx_data[7:0];
							ctrl_q[C_RXB8] = ctrl_q[C_CHR9] && it.rx_data[8];
						end
						r.read_data = rx_byte_q;
					end
					default: r.read_data = 8'h00;
				endcase
			end
			CMD_WRITE: begin
				case (it.reg_sel)
					SEL_BAUD_LO: baud_q = {hi_hold_q, v};
					SEL_BAUD_HI: hi_hold_q = v;
					SEL_CTRL: begin
						ctrl_q = v;
						poll_on_q = (v[C_TXEN] && v[C_TXCIE]) || (v[C_RXEN] && v[C_RXCIE]) ||
						            v[C_UDRIE];
					end
					SEL_STAT: if (v[S_TXC]) stat_q[S_TXC] = 1'b0;
					SEL_DATA: begin
						udre_pend_q = !stat_q[S_UDRE];
						stat_q[S_UDRE] = !stat_q[S_UDRE];
						bit_div_q = BitDivW'((32'(baud_q) + 32'd1) * 32'd16);
						tx_on_q = 1'b1;
						frames_left_q = frame_length();
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	logic [7:0]         gen_hold = '0;
	logic               gen_hi_seen = 1'b0;
	logic [BaudW-1:0]   gen_baud = '0;
	logic [BitDivW-1:0] gen_div = '0;

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_cmd(cmd_t c, logic [2:0] sel, logic [7:0] wd, logic [8:0] rx,
	                        logic [63:0] cc);
		in_item_t it;
		it.cmd = c;
		it.reg_sel = sel;
		it.write_data = wd;
		it.rx_data = rx;
		it.cycle_count = cc;
		cmd_backlog.push_back(it);
		if (c == CMD_WRITE) begin
			case (sel)
				SEL_BAUD_HI: begin
					gen_hold = wd;
					gen_hi_seen = 1'b1;
				end
				SEL_BAUD_LO: gen_baud = {gen_hold, wd};
				SEL_DATA:    gen_div = BitDivW'((32'(gen_baud) + 32'd1) * 32'd16);
				default: ;
			endcase
		end
	endtask

	task automatic push_write(logic [2:0] sel, logic [7:0] wd);
		push_cmd(CMD_WRITE, sel, wd, 9'($urandom), rnd64());
	endtask

	// tick landing on a bit boundary of the current divisor
	task automatic push_boundary_tick();
		logic [63:0] dv;
		logic [63:0] k;
		dv = 64'(gen_div);
		case ($urandom_range(0, 2))
			0: k = 64'($urandom_range(0, 40));
			1: k = 64'($urandom);
			default: k = rnd64() / dv;
		endcase
		push_cmd(CMD_TICK, 3'($urandom), 8'($urandom), 9'($urandom), k * dv);
	endtask

	// one transmit session: maybe set the rate and mode, load data, then run ticks
	// with register traffic mixed in
	task automatic push_session();
		logic [7:0] v;
		int n;
		int pick;
		if (!gen_hi_seen || $urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 7) == 0)
				v = 8'hff;
			else if ($urandom_range(0, 3) == 0)
				v = 8'($urandom);
			else
				v = 8'h00;
			push_write(SEL_BAUD_HI, v);
		end
		if ($urandom_range(0, 1) == 1) begin
			v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			push_write(SEL_BAUD_LO, v);
		end
		if ($urandom_range(0, 2) != 0) begin
			v = 8'($urandom);
			if ($urandom_range(0, 1) == 1) begin
				v[C_TXCIE] = 1'b1;
				v[C_TXEN] = 1'b1;
			end
			if ($urandom_range(0, 1) == 1)
				v[C_UDRIE] = 1'b1;
			push_write(SEL_CTRL, v);
		end
		push_write(SEL_DATA, 8'($urandom));
		n = $urandom_range(14, 40);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				push_boundary_tick();
			else if (pick < 73)
				push_cmd(CMD_TICK, 3'($urandom), 8'($urandom), 9'($urandom), rnd64());
			else if (pick < 83)
				push_cmd(CMD_READ, 3'($urandom_range(0, 7)), 8'($urandom), 9'($urandom),
				         rnd64());
			else if (pick < 88)
				push_write(SEL_STAT, 8'($urandom));
			else if (pick < 93)
				push_write(SEL_DATA, 8'($urandom));
			else if (pick < 95)
				push_write(SEL_CTRL, 8'($urandom));
			else if (pick < 97)
				push_write(SEL_BAUD_LO, 8'($urandom));
			else if (pick < 98)
				push_write(3'($urandom_range(5, 7)), 8'($urandom));
			else
				push_cmd(CMD_NONE, 3'($urandom), 8'($urandom), 9'($urandom), rnd64());
		end
	endtask

	// ------------------------------------------------------------------
	// input driver: bursts with random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 3;
	int accepted_cmds = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_replies.push_back(apply_uart_command(in_item));
				accepted_cmds++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					in_item <= cmd_backlog.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// reply side: changing stall patterns plus one long hold-off
	// ------------------------------------------------------------------
	int replies_seen = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int ready_mode = 0;
	int mode_left = 0;
	logic [1:0] stall_phase = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && replies_seen >= 120) begin
			out_ready <= 1'b0;
			hold_left <= LongHold;
			hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_phase <= stall_phase + 2'd1;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= (stall_phase == 2'd0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// reply checker
	// ------------------------------------------------------------------
	int fails = 0;
	int tx_irqs = 0;
	int udre_irqs = 0;

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			replies_seen <= replies_seen + 1;
			if (out_item.irq_tx) tx_irqs++;
			if (out_item.irq_udre) udre_irqs++;
			if (awaited_replies.size() == 0) begin
				$error("unexpected reply beat: %p", out_item);
				fails++;
			end else begin
				want = awaited_replies.pop_front();
				if (out_item.read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, out_item.read_data);
					fails++;
				end
				if (out_item.irq_rx !== want.irq_rx) begin
					$error("irq_rx: expected %0b, got %0b", want.irq_rx, out_item.irq_rx);
					fails++;
				end
				if (out_item.irq_tx !== want.irq_tx) begin
					$error("irq_tx: expected %0b, got %0b", want.irq_tx, out_item.irq_tx);
					fails++;
				end
				if (out_item.irq_udre !== want.irq_udre) begin
					$error("irq_udre: expected %0b, got %0b", want.irq_udre, out_item.irq_udre);
					fails++;
				end
			end
		end
	end

	// watchdog: no beat on either side while work is outstanding
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    (cmd_backlog.size() == 0 && !in_valid && awaited_replies.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no progress for %0d cycles", IdleLimit);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		int directed;
		// reset values of every register, unused selector, unused command
		for (int s = 0; s <= 4; s++)
			push_cmd(CMD_READ, 3'(s), 8'hff, 9'h1ff, 64'hffff_ffff_ffff_ffff);
		push_cmd(CMD_READ, 3'd5, 8'h00, 9'h000, 64'd0);
		push_cmd(CMD_NONE, 3'd7, 8'hff, 9'h1ff, 64'hffff_ffff_ffff_ffff);
		push_cmd(CMD_TICK, 3'd0, 8'h00, 9'h000, 64'd0);
		// slowest rate, eight-bit frames, frame-end and data-empty interrupts on
		push_write(SEL_BAUD_HI, 8'hff);
		push_write(SEL_BAUD_LO, 8'hff);
		push_write(SEL_CTRL, 8'h68);
		push_write(SEL_DATA, 8'h00);
		push_cmd(CMD_TICK, 3'd0, 8'h00, 9'h000, 64'hffff_ffff_ffff_ffff);
		push_cmd(CMD_READ, SEL_DATA, 8'h00, 9'h1ff, 64'd0);
		push_write(SEL_STAT, 8'h40);
		push_write(3'd6, 8'hff);
		// ten bit boundaries run the frame out and raise the completion pulse
		for (int k = 1; k <= 10; k++)
			push_cmd(CMD_TICK, 3'd0, 8'h00, 9'h000, 64'(k) << 20);
		directed = cmd_backlog.size();
		while (cmd_backlog.size() < directed + RandomCmds)
			push_session();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || awaited_replies.size() != 0);
		repeat (100) @(posedge clk);

		$display("%0d commands accepted, %0d replies checked", accepted_cmds, replies_seen);
		$display("%0d frame-end and %0d data-empty interrupts seen", tx_irqs, udre_irqs);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/uart_rtm_pkg.sv
hw/rtl/uart_register_and_tx_timing_model.sv
test/tb_top.sv
